FILE: rtl/core/pmst_pkg.sv
package pmst_pkg;

    localparam int VERTEX_BITS = 7;
    localparam int OPC_BITS    = 2;
    // widest index and weight over the parameter ranges
    localparam int IDX_BITS    = 6;
    localparam int WMAX_BITS   = 32;

    typedef enum logic [OPC_BITS-1:0] {
        OP_CLEAR = 2'd0,
        OP_EDGE  = 2'd1,
        OP_RUN   = 2'd2
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [IDX_BITS-1:0]  a;
        logic [IDX_BITS-1:0]  b;
        logic [WMAX_BITS-1:0] w;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    typedef struct packed {
        logic pop;
        logic hold;
    } t_bctl;

endpackage

FILE: rtl/core/prim_minimum_spanning_tree_top.sv
// channel   direction  handshake             payload
// input     in         i_valid / o_stall     i_opcode, i_first_vertex, i_second_vertex,
//                                            i_edge_weight
// result    out        o_valid / i_stall     o_added_vertex, o_parent_vertex,
//                                            o_link_weight, o_unreachable, o_last_result
// config    in         i_wr_en               i_wr_data (vertex_count)
//
// Edge load: two writes, one per direction, to the adjacency memory, which has a single write port.
// Clear: writes every adjacency entry (4096 by default), one entry per cycle;
// the same clearing pass runs after reset, with o_stall high throughout.
// Run with n vertices: one-read-per-cycle sweeps over the adjacency and per-vertex scratch memories.
// A two-item queue sits between intake and execution; a stalled result holds the run.
module prim_minimum_spanning_tree_top #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [pmst_pkg::OPC_BITS-1:0]    i_opcode,
    input  logic [pmst_pkg::VERTEX_BITS-1:0] i_first_vertex,
    input  logic [pmst_pkg::VERTEX_BITS-1:0] i_second_vertex,
    input  logic [WEIGHT_BITS-1:0]           i_edge_weight,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [pmst_pkg::VERTEX_BITS-1:0] o_added_vertex,
    output logic [pmst_pkg::VERTEX_BITS-1:0] o_parent_vertex,
    output logic [WEIGHT_BITS-1:0]           o_link_weight,
    output logic                             o_unreachable,
    output logic                             o_last_result,
    input  logic                             i_wr_en,
    input  logic [pmst_pkg::VERTEX_BITS-1:0] i_wr_data
);

    localparam int VW = $clog2(MAX_VERTICES);

    logic [pmst_pkg::VERTEX_BITS-1:0] r_vcount;
    logic [VW:0]                      w_n;
    pmst_pkg::t_qhead                 head;
    pmst_pkg::t_bctl                  bctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vcount <= pmst_pkg::VERTEX_BITS'(64);
        else if (i_wr_en) r_vcount <= i_wr_data;
    end

    assign w_n = (r_vcount > pmst_pkg::VERTEX_BITS'(MAX_VERTICES)) ?
                 (VW+1)'(MAX_VERTICES) : r_vcount[VW:0];

    pmst_front #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_first_vertex (i_first_vertex),
        .i_second_vertex(i_second_vertex),
        .i_edge_weight  (i_edge_weight),
        .i_ctl          (bctl),
        .o_head         (head)
    );

    pmst_back #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_n            (w_n),
        .i_head         (head),
        .o_ctl          (bctl),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_added_vertex (o_added_vertex),
        .o_parent_vertex(o_parent_vertex),
        .o_link_weight  (o_link_weight),
        .o_unreachable  (o_unreachable),
        .o_last_result  (o_last_result)
    );

`ifndef NO_ASSERTIONS
    a_unr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_unreachable |-> o_last_result)
        else $error("unreachable result not marked last");
    a_unr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_unreachable |-> (o_added_vertex == '0) && (o_parent_vertex == '0)
                                      && (o_link_weight == '0))
        else $error("unreachable result carries data");
    a_vtx_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_unreachable |-> (o_added_vertex > 7'd1) && (o_parent_vertex != '0)
                                       && (o_added_vertex != o_parent_vertex))
        else $error("bad vertex numbers in result");
`endif

endmodule

FILE: rtl/core/pmst_front.sv
module pmst_front #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pmst_pkg::OPC_BITS-1:0] i_opcode,
    input  logic [pmst_pkg::VERTEX_BITS-1:0] i_first_vertex,
    input  logic [pmst_pkg::VERTEX_BITS-1:0] i_second_vertex,
    input  logic [WEIGHT_BITS-1:0]        i_edge_weight,
    input  pmst_pkg::t_bctl               i_ctl,
    output pmst_pkg::t_qhead              o_head
);

    pmst_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    logic [pmst_pkg::VERTEX_BITS-1:0] am1, bm1;
    logic a_ok, b_ok, keep, push, pop;
    pmst_pkg::t_cmd cmd;

    always_comb begin
        am1  = i_first_vertex - pmst_pkg::VERTEX_BITS'(1);
        bm1  = i_second_vertex - pmst_pkg::VERTEX_BITS'(1);
        a_ok = (i_first_vertex != '0) &&
               (i_first_vertex <= pmst_pkg::VERTEX_BITS'(MAX_VERTICES));
        b_ok = (i_second_vertex != '0) &&
               (i_second_vertex <= pmst_pkg::VERTEX_BITS'(MAX_VERTICES));
        // bad endpoints and the unused opcode are dropped here
        keep = (i_opcode == pmst_pkg::OP_CLEAR) || (i_opcode == pmst_pkg::OP_RUN) ||
               ((i_opcode == pmst_pkg::OP_EDGE) && a_ok && b_ok);
        cmd.op = pmst_pkg::t_op'(i_opcode);
        cmd.a  = am1[pmst_pkg::IDX_BITS-1:0];
        cmd.b  = bm1[pmst_pkg::IDX_BITS-1:0];
        cmd.w  = pmst_pkg::WMAX_BITS'(i_edge_weight);
    end

    assign o_stall      = (r_cnt == 2'd2) || i_ctl.hold;
    assign push         = i_valid && !o_stall && keep;
    assign pop          = i_ctl.pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd;
                r_wp      <= !r_wp;
            end
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: rtl/core/pmst_back.sv
module pmst_back #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [$clog2(MAX_VERTICES):0]    i_n,
    input  pmst_pkg::t_qhead                 i_head,
    output pmst_pkg::t_bctl                  o_ctl,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [pmst_pkg::VERTEX_BITS-1:0] o_added_vertex,
    output logic [pmst_pkg::VERTEX_BITS-1:0] o_parent_vertex,
    output logic [WEIGHT_BITS-1:0]           o_link_weight,
    output logic                             o_unreachable,
    output logic                             o_last_result
);

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int AW     = 2 * VW;
    localparam int ADEPTH = 1 << AW;
    localparam int EW     = WEIGHT_BITS + 1;
    localparam logic [EW-1:0] NO_EDGE = {1'b1, {WEIGHT_BITS{1'b0}}};

    typedef struct packed {
        logic          in;
        logic [VW-1:0] par;
        logic [EW-1:0] link;
    } t_scr;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_EDGE2, S_INIT, S_SCAN, S_EMIT, S_UPD
    } t_state;

    t_state           r_state;
    logic [VW:0]      r_k;
    logic             r_pv;
    logic [VW-1:0]    r_pk;
    logic [VW:0]      r_iter;
    logic [VW-1:0]    r_pick;
    logic [VW-1:0]    r_bpar;
    logic [EW-1:0]    r_best;
    logic [AW-1:0]    r_clr;
    logic [VW-1:0]    r_ea, r_eb;
    logic [WEIGHT_BITS-1:0] r_ew;

    logic [EW-1:0]    r_adj [ADEPTH];
    logic [EW-1:0]    r_adj_q;
    t_scr             r_scr [MAX_VERTICES];
    t_scr             r_scr_q;

    logic             adj_we;
    logic [AW-1:0]    adj_waddr, adj_raddr;
    logic [EW-1:0]    adj_wdata;
    logic             scr_we;
    logic [VW-1:0]    scr_waddr, scr_raddr;
    t_scr             scr_wdata;

    logic [VW:0]      n_m1;
    logic [VW-1:0]    kidx;
    logic             issue, last_pk, sc_hit, up_self, up_better, out_free;

    always_comb begin
        n_m1      = i_n - 1'b1;
        kidx      = r_k[VW-1:0];
        issue     = r_k < i_n;
        last_pk   = r_pv && (r_pk == n_m1[VW-1:0]);
        sc_hit    = r_pv && !r_scr_q.in && (r_scr_q.link < r_best);
        up_self   = r_pk == r_pick;
        up_better = !r_scr_q.in && (r_adj_q < r_scr_q.link);
        out_free  = !o_valid || !i_stall;

        adj_we    = 1'b0;
        adj_waddr = r_clr;
        adj_wdata = NO_EDGE;
        adj_raddr = {VW'(0), kidx};
        scr_we    = 1'b0;
        scr_waddr = r_pk;
        scr_wdata = '{1'b0, VW'(0), r_adj_q};
        scr_raddr = kidx;
        o_ctl.pop  = 1'b0;
        o_ctl.hold = (r_state == S_CLR);

        case (r_state)
            S_CLR: adj_we = 1'b1;
            S_IDLE: begin
                o_ctl.pop = i_head.valid;
                if (i_head.valid && (i_head.cmd.op == pmst_pkg::OP_EDGE)) begin
                    adj_we    = 1'b1;
                    adj_waddr = {i_head.cmd.a[VW-1:0], i_head.cmd.b[VW-1:0]};
                    adj_wdata = {1'b0, i_head.cmd.w[WEIGHT_BITS-1:0]};
                end
            end
            S_EDGE2: begin
                adj_we    = 1'b1;
                adj_waddr = {r_eb, r_ea};
                adj_wdata = {1'b0, r_ew};
            end
            S_INIT: scr_we = r_pv;
            S_UPD: begin
                adj_raddr = {r_pick, kidx};
                if (r_pv && up_self) begin
                    scr_we    = 1'b1;
                    scr_wdata = '{1'b1, r_scr_q.par, r_scr_q.link};
                end else if (r_pv && up_better) begin
                    scr_we    = 1'b1;
                    scr_wdata = '{1'b0, r_pick, r_adj_q};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) r_adj[adj_waddr] <= adj_wdata;
        r_adj_q <= r_adj[adj_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) r_scr[scr_waddr] <= scr_wdata;
        r_scr_q <= r_scr[scr_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_pv    <= 1'b0;
            r_k     <= '0;
            r_iter  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && (r_state != S_EMIT)) o_valid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_head.valid) begin
                        case (i_head.cmd.op)
                            pmst_pkg::OP_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLR;
                            end
                            pmst_pkg::OP_EDGE: begin
                                r_ea    <= i_head.cmd.a[VW-1:0];
                                r_eb    <= i_head.cmd.b[VW-1:0];
                                r_ew    <= i_head.cmd.w[WEIGHT_BITS-1:0];
                                r_state <= S_EDGE2;
                            end
                            pmst_pkg::OP_RUN: begin
                                if (i_n >= (VW+1)'(2)) begin
                                    r_k     <= (VW+1)'(1);
                                    r_pv    <= 1'b0;
                                    r_iter  <= (VW+1)'(1);
                                    r_state <= S_INIT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_EDGE2: r_state <= S_IDLE;
                S_INIT, S_SCAN, S_UPD: begin
                    r_pv <= issue && !last_pk;
                    r_pk <= kidx;
                    if (last_pk) r_k <= (VW+1)'(1);
                    else if (issue) r_k <= r_k + 1'b1;
                    if ((r_state == S_SCAN) && sc_hit) begin
                        r_best <= r_scr_q.link;
                        r_pick <= r_pk;
                        r_bpar <= r_scr_q.par;
                    end
                    if (last_pk) begin
                        if (r_state == S_SCAN) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_best  <= NO_EDGE;
                            r_pick  <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        if (r_pick == '0) begin
                            // nothing left reachable from the tree
                            o_added_vertex  <= '0;
                            o_parent_vertex <= '0;
                            o_link_weight   <= '0;
                            o_unreachable   <= 1'b1;
                            o_last_result   <= 1'b1;
                            r_state         <= S_IDLE;
                        end else begin
                            o_added_vertex  <= pmst_pkg::VERTEX_BITS'(r_pick) +
                                               pmst_pkg::VERTEX_BITS'(1);
                            o_parent_vertex <= pmst_pkg::VERTEX_BITS'(r_bpar) +
                                               pmst_pkg::VERTEX_BITS'(1);
                            o_link_weight   <= r_best[WEIGHT_BITS-1:0];
                            o_unreachable   <= 1'b0;
                            o_last_result   <= (r_iter == n_m1);
                            r_state         <= (r_iter == n_m1) ? S_IDLE : S_UPD;
                            r_iter          <= r_iter + 1'b1;
                            r_k             <= (VW+1)'(1);
                            r_pv            <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: test/prim_minimum_spanning_tree_top_test.sv
module prim_minimum_spanning_tree_top_test;

    localparam int NV        = 64;
    localparam int WB        = 16;
    localparam int IDLE_MAX  = 60000;
    // two queued clears can still be working after the last result
    localparam int SETTLE    = 9000;
    localparam logic [pmst_pkg::OPC_BITS-1:0] OP_UNDEF = 2'd3;
    localparam logic [WB:0] NO_EDGE = 17'h10000;

    typedef struct packed {
        logic [6:0]    vtx;
        logic [6:0]    par;
        logic [WB-1:0] wgt;
        logic          unr;
        logic          last;
    } mst_result_t;

    typedef struct {
        logic [pmst_pkg::OPC_BITS-1:0] op;
        logic [6:0]          a;
        logic [6:0]          b;
        logic [WB-1:0]       w;
        bit                  typed;
        mst_result_t         res;
    } row_t;

    localparam mst_result_t UNREACH = '{7'd0, 7'd0, 16'd0, 1'b1, 1'b1};
    localparam mst_result_t NONE    = '{7'd0, 7'd0, 16'd0, 1'b0, 1'b0};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [pmst_pkg::OPC_BITS-1:0] i_opcode = '0;
    logic [6:0]             i_first_vertex = '0;
    logic [6:0]             i_second_vertex = '0;
    logic [WB-1:0]          i_edge_weight = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [6:0]             o_added_vertex;
    logic [6:0]             o_parent_vertex;
    logic [WB-1:0]          o_link_weight;
    logic                   o_unreachable;
    logic                   o_last_result;
    logic                   i_wr_en = 1'b0;
    logic [6:0]             i_wr_data = '0;

    prim_minimum_spanning_tree_top #(.MAX_VERTICES(NV), .WEIGHT_BITS(WB)) i_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [WB:0]  adj [NV][NV];
    int unsigned  vcount = 64;
    mst_result_t  tree_q[$];
    int           errors = 0;
    int           burst_left = 0;
    bit           hold_req = 0;
    int           idle_cnt = 0;

    task automatic grow_tree();
        logic [WB:0] link [NV];
        int          par [NV];
        bit          in_t [NV];
        logic [WB:0] best;
        int          n, pick;
        n = (vcount > NV) ? NV : vcount;
        if (n < 2) return;
        for (int k = 1; k < n; k++) begin
            link[k] = adj[0][k];
            par[k]  = 0;
            in_t[k] = 0;
        end
        for (int i = 1; i < n; i++) begin
            best = NO_EDGE;
            pick = 0;
            for (int k = 1; k < n; k++)
                if (!in_t[k] && link[k] < best) begin
                    best = link[k];
                    pick = k;
                end
            if (pick == 0) begin
                tree_q.push_back(UNREACH);
                return;
            end
            tree_q.push_back('{7'(pick + 1), 7'(par[pick] + 1), best[WB-1:0], 1'b0,
                               1'(i == n - 1)});
            in_t[pick] = 1;
            for (int k = 1; k < n; k++)
                if (!in_t[k] && adj[pick][k] < link[k]) begin
                    link[k] = adj[pick][k];
                    par[k]  = pick;
                end
        end
    endtask

    task automatic apply_item(input logic [1:0] op, input logic [6:0] a, input logic [6:0] b,
                              input logic [WB-1:0] w);
        case (op)
            pmst_pkg::OP_CLEAR: foreach (adj[r, c]) adj[r][c] = NO_EDGE;
            pmst_pkg::OP_EDGE: if (a >= 1 && a <= NV && b >= 1 && b <= NV) begin
                adj[a-1][b-1] = {1'b0, w};
                adj[b-1][a-1] = {1'b0, w};
            end
            pmst_pkg::OP_RUN: grow_tree();
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [1:0] op, input logic [6:0] a, input logic [6:0] b,
                             input logic [WB-1:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom % 4 != 0) begin
                gap = $urandom_range(1, 6);
                @(negedge i_clk) i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_first_vertex  <= a;
        i_second_vertex <= b;
        i_edge_weight   <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic go_idle();
        @(negedge i_clk) i_valid <= 1'b0;
        burst_left = 0;
        while (tree_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_count(input logic [6:0] v);
        go_idle();
        @(negedge i_clk);
        i_wr_en   <= 1'b1;
        i_wr_data <= v;
        @(negedge i_clk) i_wr_en <= 1'b0;
        vcount = v;
    endtask

    row_t dir_tab[14] = '{
        '{pmst_pkg::OP_RUN,   7'd0,   7'd0,   16'd0,      1, UNREACH},
        '{pmst_pkg::OP_EDGE,  7'd1,   7'd2,   16'd0,      0, NONE},
        '{pmst_pkg::OP_EDGE,  7'd2,   7'd3,   16'hFFFF,   0, NONE},
        '{pmst_pkg::OP_EDGE,  7'd0,   7'd5,   16'd5,      0, NONE},
        '{pmst_pkg::OP_EDGE,  7'd65,  7'd3,   16'd9,      0, NONE},
        '{pmst_pkg::OP_EDGE,  7'd127, 7'd127, 16'hFFFF,   0, NONE},
        '{pmst_pkg::OP_EDGE,  7'd4,   7'd4,   16'd1,      0, NONE},
        '{pmst_pkg::OP_EDGE,  7'd1,   7'd3,   16'hFFFF,   0, NONE},
        '{pmst_pkg::OP_EDGE,  7'd3,   7'd4,   16'd7,      0, NONE},
        '{pmst_pkg::OP_EDGE,  7'd2,   7'd3,   16'd3,      0, NONE},
        '{OP_UNDEF,           7'd127, 7'd127, 16'hFFFF,   0, NONE},
        '{pmst_pkg::OP_RUN,   7'd0,   7'd0,   16'd0,      0, NONE},
        '{pmst_pkg::OP_CLEAR, 7'd0,   7'd0,   16'd0,      0, NONE},
        '{pmst_pkg::OP_RUN,   7'd0,   7'd0,   16'd0,      1, UNREACH}
    };

    int unsigned phase_cnt[12] = '{2, 3, 5, 8, 16, 64, 100, 1, 0, 12, 4, 127};

    initial begin
        int n;
        logic [1:0] op;
        logic [6:0] a, b;
        logic [WB-1:0] w;
        foreach (adj[r, c]) adj[r][c] = NO_EDGE;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].w);
            if (dir_tab[i].typed) tree_q.push_back(dir_tab[i].res);
            else apply_item(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].w);
        end

        foreach (phase_cnt[p]) begin
            set_count(7'(phase_cnt[p]));
            n = (phase_cnt[p] < 2) ? 8 : (phase_cnt[p] > NV ? NV : phase_cnt[p]);
            if (p % 2 == 0) begin
                send_item(pmst_pkg::OP_CLEAR, 7'd0, 7'd0, 16'd0);
                apply_item(pmst_pkg::OP_CLEAR, 7'd0, 7'd0, 16'd0);
            end
            for (int j = 1; j <= 38; j++) begin
                a = 7'($urandom_range(1, n));
                b = 7'($urandom_range(1, n));
                w = ($urandom % 2) ? 16'($urandom_range(0, 3)) : 16'($urandom);
                if (j % 12 == 0 || j == 38) op = pmst_pkg::OP_RUN;
                else if ($urandom % 10 == 0) begin
                    // noise: any endpoints, any opcode but clear
                    op = 2'($urandom_range(1, 3));
                    a  = 7'($urandom);
                    b  = 7'($urandom);
                end else op = pmst_pkg::OP_EDGE;
                send_item(op, a, b, w);
                apply_item(op, a, b, w);
                if (p == 4 && j == 12) hold_req = 1;
            end
        end

        @(negedge i_clk) i_valid <= 1'b0;
        while (tree_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && tree_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // result side stall pattern, with one long hold-off on request
    initial begin
        int len, mode;
        forever begin
            if (hold_req) begin
                hold_req = 0;
                @(negedge i_clk) i_stall <= 1'b1;
                repeat (3000) @(negedge i_clk);
            end
            len  = $urandom_range(1, 40);
            mode = $urandom % 3;
            repeat (len) begin
                @(negedge i_clk);
                i_stall <= (mode == 0) ? 1'b0 :
                           (mode == 1) ? ($urandom % 4 == 0) : 1'($urandom % 2);
            end
        end
    end

    always @(posedge i_clk) begin
        mst_result_t got, exp_r;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_added_vertex, o_parent_vertex, o_link_weight, o_unreachable,
                        o_last_result};
                if (tree_q.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, got);
                    errors++;
                end else begin
                    exp_r = tree_q.pop_front();
                    if (got.vtx !== exp_r.vtx)
                        $display("%0t: vertex exp %0d got %0d", $time, exp_r.vtx, got.vtx);
                    if (got.par !== exp_r.par)
                        $display("%0t: parent exp %0d got %0d", $time, exp_r.par, got.par);
                    if (got.wgt !== exp_r.wgt)
                        $display("%0t: weight exp %0d got %0d", $time, exp_r.wgt, got.wgt);
                    if (got.unr !== exp_r.unr)
                        $display("%0t: unreach exp %0d got %0d", $time, exp_r.unr, got.unr);
                    if (got.last !== exp_r.last)
                        $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
                    if (got !== exp_r) errors++;
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= IDLE_MAX) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end
endmodule
